>>> rtl/core/assert_macros.svh
// Assertion macros used by the port-level checker of the core.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define RAU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define RAU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/rau_pkg.sv
// Shared types and constants of the rational arithmetic core.
// No dependencies.
`default_nettype none
package rau_pkg;

    localparam int NUM_WIDTH   = 16;
    localparam int DEN_WIDTH   = NUM_WIDTH - 1;
    localparam int PROD_WIDTH  = 2 * NUM_WIDTH;
    localparam int SUM_WIDTH   = PROD_WIDTH + 1;
    localparam int MAG_WIDTH   = PROD_WIDTH;
    localparam int SHIFT_WIDTH = $clog2(MAG_WIDTH + 1);
    localparam int CNT_WIDTH   = $clog2(MAG_WIDTH);

    localparam int IN_FIELDS_W = 2 * NUM_WIDTH + 2 * DEN_WIDTH;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;

    localparam int RES_NUM_WIDTH = 32;
    localparam int RES_DEN_WIDTH = 31;
    localparam int OUT_TDATA_W   = ((RES_NUM_WIDTH + RES_DEN_WIDTH + 7) / 8) * 8;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } rau_op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_DEN = 2'd1,
        ST_DIV_ZERO = 2'd2
    } rau_status_t;

    typedef struct packed {
        rau_op_t                      op;
        logic signed [NUM_WIDTH-1:0]  a_num;
        logic        [DEN_WIDTH-1:0]  a_den;
        logic signed [NUM_WIDTH-1:0]  b_num;
        logic        [DEN_WIDTH-1:0]  b_den;
        rau_status_t                  status;
    } rau_item_t;

endpackage
`default_nettype wire

>>> rtl/core/rational_arithmetic_unit_core.sv
// Top level of the rational arithmetic core: front end, queue, back end.
// Depends on rau_pkg, rau_front, rau_back.
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  tdata: a_num, a_den, b_num, b_den; tuser: op
//  m_*      out  m_tvalid/m_tready  tdata: res_num, res_den; tuser: status
//
// Each item passes the pop in S_IDLE, the multiplier states S_MUL0 to S_MUL2,
// the sign state, the binary GCD loop and its closing step, the divider loop
// of S_DIV, then the output state S_OUT.
// Error items go from the pop straight to the output state.
// The back end handles one item at a time; the two-entry queue takes transfers
// while it works until full, and the output register holds a result under stall.
// Reset is asynchronous, active low, and empties queue and output register.
`default_nettype none
module rational_arithmetic_unit_core
    import rau_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // a_num[15:0], a_den[30:16], b_num[46:31], b_den[61:47], zero pad
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    // op[1:0]
    input  wire logic [1:0]             s_tuser,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // res_num[31:0], res_den[62:32], zero pad
    output logic [OUT_TDATA_W-1:0]      m_tdata,
    // status[1:0]
    output logic [1:0]                  m_tuser
);

    logic      item_valid;
    logic      item_pop;
    rau_item_t item;

    // Accept and classify; queue decouples from the arithmetic.
    rau_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop)
    );

    // Cross-multiply, reduce by GCD, register the result transfer.
    rau_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule
`default_nettype wire

>>> rtl/core/rau_front.sv
// Front end: accepts input transfers, classifies errors, holds a two-entry queue.
// Depends on rau_pkg.
`default_nettype none
module rau_front
    import rau_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_TDATA_W-1:0] s_tdata,
    input  wire logic [1:0]            s_tuser,
    output logic                       item_valid,
    output rau_item_t                  item,
    input  wire logic                  item_pop
);

    rau_item_t  fifo_mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    rau_item_t  in_item;
    logic       push, pop;

    always_comb
    begin
        in_item.op    = rau_op_t'(s_tuser);
        in_item.a_num = s_tdata[NUM_WIDTH-1:0];
        in_item.a_den = s_tdata[NUM_WIDTH+DEN_WIDTH-1:NUM_WIDTH];
        in_item.b_num = s_tdata[2*NUM_WIDTH+DEN_WIDTH-1:NUM_WIDTH+DEN_WIDTH];
        in_item.b_den = s_tdata[IN_FIELDS_W-1:2*NUM_WIDTH+DEN_WIDTH];
        if (in_item.a_den == '0 || in_item.b_den == '0)
        begin
            in_item.status = ST_ZERO_DEN;
        end
        else if (in_item.op == OP_DIV && in_item.b_num == '0)
        begin
            in_item.status = ST_DIV_ZERO;
        end
        else
        begin
            in_item.status = ST_OK;
        end
    end

    assign s_tready   = (count_reg != 2'd2);
    assign item_valid = (count_reg != 2'd0);
    assign item       = fifo_mem[rd_ptr_reg];
    assign push       = s_tvalid && s_tready;
    assign pop        = item_pop && item_valid;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/rau_back.sv
// Back end: shared multiplier, binary GCD, bit-serial dividers, output register.
// Depends on rau_pkg.
`default_nettype none
module rau_back
    import rau_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   item_valid,
    input  wire rau_item_t              item,
    output logic                        item_pop,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata,
    output logic [1:0]                  m_tuser
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_MUL0 = 8'b0000_0010,
        S_MUL1 = 8'b0000_0100,
        S_MUL2 = 8'b0000_1000,
        S_SIGN = 8'b0001_0000,
        S_GCD  = 8'b0010_0000,
        S_DIV  = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } state_t;

    state_t                      state_reg, state_next;
    logic                        m_valid_reg, m_valid_next;
    rau_item_t                   cur_reg;
    logic signed [PROD_WIDTH-1:0] p0_reg, p1_reg, p2_reg;
    logic                        neg_reg;
    logic [MAG_WIDTH-1:0]        nm_reg, dm_reg, u_reg, v_reg, g_reg;
    logic [SHIFT_WIDTH-1:0]      k_reg;
    logic [MAG_WIDTH:0]          rn_reg, rd_reg;
    logic [MAG_WIDTH-1:0]        qn_reg, qd_reg;
    logic [CNT_WIDTH-1:0]        cnt_reg;
    logic [OUT_TDATA_W-1:0]      tdata_reg;
    logic [1:0]                  tuser_reg;

    logic signed [NUM_WIDTH-1:0]  mul_x, mul_y;
    logic signed [PROD_WIDTH-1:0] prod;
    logic signed [NUM_WIDTH-1:0]  ad_s, bd_s;
    logic signed [SUM_WIDTH-1:0]  n_sum, d_ext;
    logic [MAG_WIDTH:0]           rn_sh, rd_sh;
    logic                         gcd_done, load_out;
    logic signed [MAG_WIDTH:0]    num_s;
    logic                         neg_final;

    assign ad_s = $signed({1'b0, cur_reg.a_den});
    assign bd_s = $signed({1'b0, cur_reg.b_den});

    // One multiplier, operands picked by step and operation.
    always_comb
    begin
        mul_x = cur_reg.a_num;
        mul_y = bd_s;
        unique case (1'b1)
            state_reg[2]:
            begin
                mul_x = (cur_reg.op == OP_ADD || cur_reg.op == OP_SUB) ? cur_reg.b_num : '0;
                mul_y = ad_s;
            end
            state_reg[3]:
            begin
                mul_x = ad_s;
                mul_y = (cur_reg.op == OP_DIV) ? cur_reg.b_num : bd_s;
            end
            default:
            begin
                mul_x = cur_reg.a_num;
                mul_y = (cur_reg.op == OP_MUL) ? cur_reg.b_num : bd_s;
            end
        endcase
    end
    assign prod = mul_x * mul_y;

    always_comb
    begin
        if (cur_reg.op == OP_SUB)
        begin
            n_sum = SUM_WIDTH'(p0_reg) - SUM_WIDTH'(p1_reg);
        end
        else
        begin
            n_sum = SUM_WIDTH'(p0_reg) + SUM_WIDTH'(p1_reg);
        end
        d_ext = SUM_WIDTH'(p2_reg);
    end

    assign gcd_done = (u_reg == '0) || (v_reg == '0);
    assign rn_sh    = {rn_reg[MAG_WIDTH-1:0], qn_reg[MAG_WIDTH-1]};
    assign rd_sh    = {rd_reg[MAG_WIDTH-1:0], qd_reg[MAG_WIDTH-1]};
    assign load_out = state_reg[7] && (!m_valid_reg || m_tready);
    assign item_pop = state_reg[0] && item_valid;

    assign neg_final = neg_reg && (qn_reg != '0);
    assign num_s     = neg_final ? -$signed({1'b0, qn_reg}) : $signed({1'b0, qn_reg});

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (item_valid) state_next = (item.status == ST_OK) ? S_MUL0 : S_OUT;
            S_MUL0: state_next = S_MUL1;
            S_MUL1: state_next = S_MUL2;
            S_MUL2: state_next = S_SIGN;
            S_SIGN: state_next = S_GCD;
            S_GCD:  if (gcd_done) state_next = S_DIV;
            S_DIV:  if (cnt_reg == CNT_WIDTH'(MAG_WIDTH - 1)) state_next = S_OUT;
            S_OUT:  if (load_out) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (load_out)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_pop)
        begin
            cur_reg <= item;
            qn_reg  <= '0;
            qd_reg  <= '0;
            neg_reg <= 1'b0;
        end
        if (state_reg[1]) p0_reg <= prod;
        if (state_reg[2]) p1_reg <= prod;
        if (state_reg[3]) p2_reg <= prod;
        if (state_reg[4])
        begin
            neg_reg <= n_sum[SUM_WIDTH-1] ^ d_ext[SUM_WIDTH-1];
            nm_reg  <= MAG_WIDTH'(n_sum[SUM_WIDTH-1] ? -n_sum : n_sum);
            dm_reg  <= MAG_WIDTH'(d_ext[SUM_WIDTH-1] ? -d_ext : d_ext);
            u_reg   <= MAG_WIDTH'(n_sum[SUM_WIDTH-1] ? -n_sum : n_sum);
            v_reg   <= MAG_WIDTH'(d_ext[SUM_WIDTH-1] ? -d_ext : d_ext);
            k_reg   <= '0;
        end
        // Binary GCD, one step a cycle.
        if (state_reg[5])
        begin
            if (gcd_done)
            begin
                g_reg   <= MAG_WIDTH'((u_reg | v_reg) << k_reg);
                rn_reg  <= '0;
                rd_reg  <= '0;
                qn_reg  <= nm_reg;
                qd_reg  <= dm_reg;
                cnt_reg <= '0;
            end
            else if (!u_reg[0] && !v_reg[0])
            begin
                u_reg <= u_reg >> 1;
                v_reg <= v_reg >> 1;
                k_reg <= k_reg + 1'b1;
            end
            else if (!u_reg[0])
            begin
                u_reg <= u_reg >> 1;
            end
            else if (!v_reg[0])
            begin
                v_reg <= v_reg >> 1;
            end
            else if (u_reg >= v_reg)
            begin
                u_reg <= u_reg - v_reg;
            end
            else
            begin
                v_reg <= v_reg - u_reg;
            end
        end
        // Two restoring dividers by the GCD, one quotient bit a cycle.
        if (state_reg[6])
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (rn_sh >= {1'b0, g_reg})
            begin
                rn_reg <= rn_sh - {1'b0, g_reg};
                qn_reg <= {qn_reg[MAG_WIDTH-2:0], 1'b1};
            end
            else
            begin
                rn_reg <= rn_sh;
                qn_reg <= {qn_reg[MAG_WIDTH-2:0], 1'b0};
            end
            if (rd_sh >= {1'b0, g_reg})
            begin
                rd_reg <= rd_sh - {1'b0, g_reg};
                qd_reg <= {qd_reg[MAG_WIDTH-2:0], 1'b1};
            end
            else
            begin
                rd_reg <= rd_sh;
                qd_reg <= {qd_reg[MAG_WIDTH-2:0], 1'b0};
            end
        end
        if (load_out)
        begin
            tdata_reg <= OUT_TDATA_W'({RES_DEN_WIDTH'(qd_reg), RES_NUM_WIDTH'(num_s)});
            tuser_reg <= cur_reg.status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tuser  = tuser_reg;

endmodule
`default_nettype wire

>>> rtl/core/rau_checker.sv
// Port-level checker for the rational arithmetic core, bound to the top level.
// Depends on rau_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module rau_checker
    import rau_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   s_tvalid,
    input wire logic                   s_tready,
    input wire logic [IN_TDATA_W-1:0]  s_tdata,
    input wire logic [1:0]             s_tuser,
    input wire logic                   m_tvalid,
    input wire logic                   m_tready,
    input wire logic [OUT_TDATA_W-1:0] m_tdata,
    input wire logic [1:0]             m_tuser
);

    `RAU_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed under stall")
    `RAU_ASSERT_NOW(a_status_code, clk, rst_n, m_tvalid, m_tuser == ST_OK || m_tuser == ST_ZERO_DEN || m_tuser == ST_DIV_ZERO, "unknown status")
    `RAU_ASSERT_NOW(a_err_zero, clk, rst_n, m_tvalid && m_tuser != ST_OK, m_tdata == '0, "error result not zero")
    `RAU_ASSERT_NOW(a_ok_den, clk, rst_n, m_tvalid && m_tuser == ST_OK, m_tdata[RES_NUM_WIDTH+RES_DEN_WIDTH-1:RES_NUM_WIDTH] != '0, "zero denominator on ok result")

endmodule

bind rational_arithmetic_unit_core rau_checker u_rau_checker (.*);
`default_nettype wire

>>> tb/rau_checker.sv
// Result checker for the rational arithmetic core: watches both stream channels,
// predicts each result and compares it. Depends on rau_pkg.
`timescale 1ns / 1ps
module rau_scoreboard
    import rau_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    input  wire logic                   s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    input  wire logic [1:0]             s_tuser,
    input  wire logic                   m_tvalid,
    input  wire logic                   m_tready,
    input  wire logic [OUT_TDATA_W-1:0] m_tdata,
    input  wire logic [1:0]             m_tuser,
    output int                          fail_count,
    output int                          pending
);

    typedef struct packed {
        logic signed [31:0] num;
        logic        [30:0] den;
        rau_status_t        status;
    } fraction_t;

    fraction_t reduced_q[$];

    function automatic longint unsigned gcd64(longint unsigned x, longint unsigned y);
        longint unsigned t;
        while (y != 0)
        begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    function automatic fraction_t reduce_fraction(rau_op_t op, logic [IN_TDATA_W-1:0] d);
        fraction_t r;
        longint an, ad, bn, bd, n, q;
        longint unsigned nm, dm, g;
        bit neg;
        an = longint'($signed(d[15:0]));
        ad = longint'(d[30:16]);
        bn = longint'($signed(d[46:31]));
        bd = longint'(d[61:47]);
        r  = '0;
        if (ad == 0 || bd == 0)
        begin
            r.status = ST_ZERO_DEN;
            return r;
        end
        if (op == OP_DIV && bn == 0)
        begin
            r.status = ST_DIV_ZERO;
            return r;
        end
        case (op)
            OP_ADD:  begin n = an * bd + bn * ad; q = ad * bd; end
            OP_SUB:  begin n = an * bd - bn * ad; q = ad * bd; end
            OP_MUL:  begin n = an * bn; q = ad * bd; end
            default: begin n = an * bd; q = ad * bn; end
        endcase
        neg = (n < 0) != (q < 0);
        nm  = (n < 0) ? -n : n;
        dm  = (q < 0) ? -q : q;
        g   = gcd64(nm, dm);
        if (g == 0)
            g = 1;
        nm = nm / g;
        dm = dm / g;
        if (nm == 0)
            neg = 0;
        r.num    = neg ? -nm[31:0] : nm[31:0];
        r.den    = dm[30:0];
        r.status = ST_OK;
        return r;
    endfunction

    assign pending = reduced_q.size();

    always @(posedge clk)
    begin
        fraction_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                reduced_q.push_back(reduce_fraction(rau_op_t'(s_tuser), s_tdata));
            if (m_tvalid && m_tready)
            begin
                if (reduced_q.size() == 0)
                begin
                    $display("%0t: unexpected result num=%0d den=%0d status=%0d",
                             $time, $signed(m_tdata[31:0]), m_tdata[62:32], m_tuser);
                    fail_count++;
                end
                else
                begin
                    want = reduced_q.pop_front();
                    if (want.num !== m_tdata[31:0] || want.den !== m_tdata[62:32]
                        || want.status !== m_tuser)
                    begin
                        $display("%0t: expected num=%0d den=%0d status=%0d, got num=%0d den=%0d status=%0d",
                                 $time, want.num, want.den, want.status,
                                 $signed(m_tdata[31:0]), m_tdata[62:32], m_tuser);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

>>> tb/tb_rational_arithmetic_unit_core.sv
// Stimulus and verdict for the rational arithmetic core.
// Depends on rau_pkg, rational_arithmetic_unit_core and rau_scoreboard.
`timescale 1ns / 1ps
module tb_rational_arithmetic_unit_core;
    import rau_pkg::*;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic [1:0]             s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [1:0]             m_tuser;
    int                     fail_count;
    int                     pending;
    longint                 cycle_count;
    bit                     sending;

    rational_arithmetic_unit_core DUT (.*);

    rau_scoreboard checker_i (.*);

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // Overall watchdog: sized for 1000+ items with random gaps and stalls.
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > 2000000)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver: random stall per transfer, with some unstalled stretches.
    initial
    begin
        int gap;
        m_tready = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            m_tready = 0;
            repeat (gap) @(negedge clk);
            m_tready = 1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    task automatic send_item(rau_op_t op, logic signed [15:0] an, logic [14:0] ad,
                             logic signed [15:0] bn, logic [14:0] bd, int gap);
        if (gap > 0)
        begin
            s_tvalid = 0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1;
        s_tuser  = op;
        s_tdata  = '0;
        s_tdata[61:0] = {bd, bn, ad, an};
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
    endtask

    function automatic logic [14:0] rand_den();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 15'h7fff;
            2, 3:    return 15'd1;
            4, 5:    return 15'($urandom_range(1, 12));
            default: return 15'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_num();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 16'h8000;
            2:       return 16'h7fff;
            3, 4:    return 16'($signed($urandom_range(0, 24)) - 12);
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        int gap;
        rst_n    = 0;
        s_tvalid = 0;
        s_tdata  = '0;
        s_tuser  = OP_ADD;
        repeat (10) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // Directed: extremes, every operation, both error codes and zero results.
        send_item(OP_ADD, 16'sd1, 15'd2, 16'sd1, 15'd3, 0);
        send_item(OP_SUB, 16'sd1, 15'd2, 16'sd1, 15'd2, 0);
        send_item(OP_MUL, -16'sd3, 15'd4, 16'sd8, 15'd9, 1);
        send_item(OP_DIV, 16'sd3, 15'd4, -16'sd9, 15'd8, 0);
        send_item(OP_ADD, 16'sd5, 15'd0, 16'sd1, 15'd1, 0);
        send_item(OP_DIV, 16'sd5, 15'd1, 16'sd0, 15'd0, 0);
        send_item(OP_DIV, 16'sd5, 15'd3, 16'sd0, 15'd7, 2);
        send_item(OP_MUL, 16'sd0, 15'd7, -16'sd4, 15'd3, 0);
        send_item(OP_ADD, -16'sh8000, 15'h7fff, -16'sh8000, 15'h7fff, 0);
        send_item(OP_SUB, 16'sh7fff, 15'd1, -16'sh8000, 15'h7fff, 0);
        send_item(OP_MUL, -16'sh8000, 15'd1, -16'sh8000, 15'd1, 0);
        send_item(OP_DIV, -16'sh8000, 15'h7fff, -16'sd1, 15'h7fff, 0);
        send_item(OP_DIV, 16'sh7fff, 15'd1, -16'sh8000, 15'h7ffe, 0);
        send_item(OP_MUL, 16'shffff, 15'h7fff, 16'shffff, 15'h7fff, 3);
        send_item(OP_ADD, 16'sh5555, 15'h2aaa, 16'shaaaa, 15'h5555, 0);
        send_item(OP_SUB, 16'sd0, 15'd9, 16'sd0, 15'd4, 0);
        send_item(OP_ADD, 16'sd6, 15'd4, 16'sd6, 15'd4, 0);

        // Hold off until the pipeline drains.
        s_tvalid = 0;
        while (pending != 0) @(negedge clk);

        for (int i = 0; i < 1000; i++)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            send_item(rau_op_t'($urandom_range(0, 3)), rand_num(), rand_den(),
                      rand_num(), rand_den(), gap);
        end
        s_tvalid = 0;

        while (pending != 0) @(negedge clk);
        repeat (200) @(negedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/rau_pkg.sv
rtl/core/rau_front.sv
rtl/core/rau_back.sv
rtl/core/rational_arithmetic_unit_core.sv
rtl/core/rau_checker.sv
tb/rau_checker.sv
tb/tb_rational_arithmetic_unit_core.sv
